>>> rtl/core/bto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bto_pkg
// Shared types and constants for the binned time offset statistics block.
// ----------------------------------------------------------------------------
package bto_pkg;

  // bin layout
  localparam int NUM_BINS   = 100;
  localparam int BIN_DEPTH  = NUM_BINS + 1;          // last entry is the outlier bin
  localparam int BIN_W      = $clog2(BIN_DEPTH);
  localparam int NS_PER_BIN = 1000;

  // field widths
  localparam int REQ_W     = 2;
  localparam int NS_W      = 63;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = 32;
  localparam int SEL_W     = 7;
  localparam int OUT_BIN_W = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // round trips in [0, TRIP_LIMIT) land in a normal bin
  localparam int TRIP_LIMIT = NUM_BINS * NS_PER_BIN;
  localparam int X_W        = $clog2(TRIP_LIMIT);
  localparam logic signed [VAL_W-1:0] TRIP_LIMIT_S = VAL_W'(TRIP_LIMIT);
  localparam logic signed [VAL_W-1:0] NEG_LIMIT_S  = -$signed(VAL_W'(NS_PER_BIN));

  // divide by NS_PER_BIN as multiply by a rounded-up reciprocal, exact below TRIP_LIMIT
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_MUL   = (2**RECIP_SHIFT + NS_PER_BIN - 1) / NS_PER_BIN;
  localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
  localparam int PROD_W      = X_W + RECIP_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_IGNORE = 2'd3
  } req_e;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] min_trip;
    logic signed [VAL_W-1:0] max_trip;
    logic signed [VAL_W-1:0] min_offset;
    logic signed [VAL_W-1:0] max_offset;
  } bin_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch accepted item
    logic calc_trip;  // round trip
    logic calc_half;  // halved round trip, bin multiply
    logic calc_bin;   // midpoint, bin index
    logic rd_bin;     // bin memory read, offset
    logic update;     // write back, load result
  } cmd_t;

endpackage

>>> rtl/core/bto_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bto_ctrl
// Sequencer for one item at a time plus the result valid flag.
// ----------------------------------------------------------------------------
module bto_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [bto_pkg::REQ_W-1:0]     in_req_type,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bto_pkg::cmd_t                 cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TRIP = 6'b000010,
    ST_HALF = 6'b000100,
    ST_BIN  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_UPD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (bto_pkg::req_e'(in_req_type))
            bto_pkg::REQ_RECORD: state_nxt = ST_TRIP;
            bto_pkg::REQ_READ:   state_nxt = ST_RD;
            bto_pkg::REQ_CLEAR,
            bto_pkg::REQ_IGNORE: state_nxt = ST_UPD;
            default:             state_nxt = ST_UPD;
          endcase
        end
      end
      ST_TRIP: begin
        cmd.calc_trip = 1'b1;
        state_nxt     = ST_HALF;
      end
      ST_HALF: begin
        cmd.calc_half = 1'b1;
        state_nxt     = ST_BIN;
      end
      ST_BIN: begin
        cmd.calc_bin = 1'b1;
        state_nxt    = ST_RD;
      end
      ST_RD: begin
        cmd.rd_bin = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register can take the item
        if (out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/bto_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bto_datapath
// Round trip, offset and bin arithmetic, bin memory and result registers.
// ----------------------------------------------------------------------------
module bto_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bto_pkg::cmd_t                        cmd,
  input  logic [bto_pkg::REQ_W-1:0]            in_req_type,
  input  logic [bto_pkg::NS_W-1:0]             in_master_send_ns,
  input  logic [bto_pkg::NS_W-1:0]             in_master_receive_ns,
  input  logic [bto_pkg::NS_W-1:0]             in_slave_time_ns,
  input  logic [bto_pkg::SEL_W-1:0]            in_read_bin,
  output logic signed [bto_pkg::VAL_W-1:0]     out_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_offset_ns,
  output logic [bto_pkg::OUT_BIN_W-1:0]        out_bin_number,
  output logic [bto_pkg::CNT_W-1:0]            out_sample_count,
  output logic signed [bto_pkg::VAL_W-1:0]     out_min_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_max_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_min_offset_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_max_offset_ns
);

  localparam int VW = bto_pkg::VAL_W;
  localparam int BW = bto_pkg::BIN_W;
  localparam int PW = bto_pkg::PROD_W;
  localparam logic [bto_pkg::CNT_W-1:0] CNT_ONE = bto_pkg::CNT_W'(1);

  // bin memory and flash-clearable used bits
  bto_pkg::bin_entry_t mem [bto_pkg::BIN_DEPTH];
  logic [bto_pkg::BIN_DEPTH-1:0] used_r;

  bto_pkg::req_e              req_r;
  logic [bto_pkg::NS_W-1:0]   send_r, recv_r, slave_r;
  logic signed [VW-1:0]       trip_r, half_r, mid_r, off_r;
  logic [PW-1:0]              prod_r;
  logic                       in_range_r, neg_small_r;
  logic [BW-1:0]              bin_r, bin_nxt, sel_bin;
  bto_pkg::bin_entry_t        rd_r, new_entry;
  logic                       rd_used_r;

  logic signed [VW-1:0]       trip_adj;
  logic [bto_pkg::X_W-1:0]    trip_x;

  logic signed [VW-1:0]       res_trip, res_off;
  logic [BW-1:0]              res_bin;
  bto_pkg::bin_entry_t        res_entry;

  // read index saturates to the outlier bin
  assign sel_bin = (32'(in_read_bin) > 32'(bto_pkg::NUM_BINS)) ?
                   BW'(bto_pkg::NUM_BINS) : BW'(in_read_bin);

  // truncate toward zero: add one to negatives before the shift
  assign trip_adj = trip_r + VW'(trip_r[VW-1]);
  assign trip_x   = trip_r[bto_pkg::X_W-1:0];

  always_comb begin
    bin_nxt = bin_r;
    if (cmd.capture) begin
      bin_nxt = sel_bin;
    end else if (cmd.calc_bin) begin
      priority if (in_range_r) begin
        bin_nxt = prod_r[bto_pkg::RECIP_SHIFT +: BW];
      end else if (neg_small_r) begin
        bin_nxt = '0;
      end else begin
        bin_nxt = BW'(bto_pkg::NUM_BINS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= bto_pkg::req_e'(in_req_type);
      send_r  <= in_master_send_ns;
      recv_r  <= in_master_receive_ns;
      slave_r <= in_slave_time_ns;
    end
    if (cmd.calc_trip) begin
      trip_r <= $signed({1'b0, recv_r}) - $signed({1'b0, send_r});
    end
    if (cmd.calc_half) begin
      half_r      <= {trip_adj[VW-1], trip_adj[VW-1:1]};
      prod_r      <= PW'(trip_x) * PW'(bto_pkg::RECIP_MUL);
      in_range_r  <= !trip_r[VW-1] && (trip_r < bto_pkg::TRIP_LIMIT_S);
      neg_small_r <= trip_r[VW-1] && (trip_r > bto_pkg::NEG_LIMIT_S);
    end
    if (cmd.calc_bin) begin
      mid_r <= $signed({1'b0, send_r}) + half_r;
    end
    bin_r <= bin_nxt;
    if (cmd.rd_bin) begin
      off_r     <= $signed({1'b0, slave_r}) - mid_r;
      rd_r      <= mem[bin_r];
      rd_used_r <= used_r[bin_r];
    end
  end

  // merge the sample into the bin just read
  always_comb begin
    new_entry = rd_r;
    if (!rd_used_r) begin
      new_entry.count      = CNT_ONE;
      new_entry.min_trip   = trip_r;
      new_entry.max_trip   = trip_r;
      new_entry.min_offset = off_r;
      new_entry.max_offset = off_r;
    end else begin
      if (rd_r.count != bto_pkg::COUNT_MAX) new_entry.count = rd_r.count + CNT_ONE;
      if (trip_r < rd_r.min_trip)  new_entry.min_trip   = trip_r;
      if (trip_r > rd_r.max_trip)  new_entry.max_trip   = trip_r;
      if (off_r < rd_r.min_offset) new_entry.min_offset = off_r;
      if (off_r > rd_r.max_offset) new_entry.max_offset = off_r;
    end
  end

  always_comb begin
    res_trip  = '0;
    res_off   = '0;
    res_bin   = '0;
    res_entry = '0;
    unique case (req_r)
      bto_pkg::REQ_RECORD: begin
        res_trip  = trip_r;
        res_off   = off_r;
        res_bin   = bin_r;
        res_entry = new_entry;
      end
      bto_pkg::REQ_READ: begin
        res_bin = bin_r;
        if (rd_used_r) res_entry = rd_r;
      end
      bto_pkg::REQ_CLEAR,
      bto_pkg::REQ_IGNORE: begin
        res_bin = '0;
      end
      default: res_bin = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (req_r == bto_pkg::REQ_RECORD)) begin
      mem[bin_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.update) begin
      if (req_r == bto_pkg::REQ_RECORD) begin
        used_r[bin_r] <= 1'b1;
      end else if (req_r == bto_pkg::REQ_CLEAR) begin
        used_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_round_trip_ns     <= res_trip;
      out_offset_ns         <= res_off;
      out_bin_number        <= bto_pkg::OUT_BIN_W'(res_bin);
      out_sample_count      <= res_entry.count;
      out_min_round_trip_ns <= res_entry.min_trip;
      out_max_round_trip_ns <= res_entry.max_trip;
      out_min_offset_ns     <= res_entry.min_offset;
      out_max_offset_ns     <= res_entry.max_offset;
    end
  end

endmodule

>>> rtl/core/binned_time_offset_stats.sv
`timescale 1ns / 1ps
// the sequencer walks one item at a time: a record item steps through trip, halve/multiply,
// bin, memory read and write-back states; a read item goes to memory read and write-back,
// a clear or ignored item straight to write-back; write-back waits while a result is held
// and stalled, and a new item is accepted only once the sequencer is back in idle
// a result may wait in the output register while the next item is taken and worked on
// reset (rst_n low, synchronous): all bins empty at once, no item in flight, no result held
// ----------------------------------------------------------------------------
// binned_time_offset_stats
// Two-way time transfer statistics: per round-trip bin count and min/max of
// round trip and offset, with clear and read requests.
// ----------------------------------------------------------------------------
module binned_time_offset_stats (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bto_pkg::REQ_W-1:0]            in_req_type,
  input  logic [bto_pkg::NS_W-1:0]             in_master_send_ns,
  input  logic [bto_pkg::NS_W-1:0]             in_master_receive_ns,
  input  logic [bto_pkg::NS_W-1:0]             in_slave_time_ns,
  input  logic [bto_pkg::SEL_W-1:0]            in_read_bin,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bto_pkg::VAL_W-1:0]     out_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_offset_ns,
  output logic [bto_pkg::OUT_BIN_W-1:0]        out_bin_number,
  output logic [bto_pkg::CNT_W-1:0]            out_sample_count,
  output logic signed [bto_pkg::VAL_W-1:0]     out_min_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_max_round_trip_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_min_offset_ns,
  output logic signed [bto_pkg::VAL_W-1:0]     out_max_offset_ns
);

  // step commands from the sequencer to the datapath
  bto_pkg::cmd_t cmd;

  // sequencer: takes one item while idle, steps it through the datapath,
  // and holds the write-back until the output register is free
  bto_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  // datapath: round trip, offset, bin select by reciprocal multiply,
  // bin memory with flash-cleared used bits, result register
  bto_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_req_type           (in_req_type),
    .in_master_send_ns     (in_master_send_ns),
    .in_master_receive_ns  (in_master_receive_ns),
    .in_slave_time_ns      (in_slave_time_ns),
    .in_read_bin           (in_read_bin),
    .out_round_trip_ns     (out_round_trip_ns),
    .out_offset_ns         (out_offset_ns),
    .out_bin_number        (out_bin_number),
    .out_sample_count      (out_sample_count),
    .out_min_round_trip_ns (out_min_round_trip_ns),
    .out_max_round_trip_ns (out_max_round_trip_ns),
    .out_min_offset_ns     (out_min_offset_ns),
    .out_max_offset_ns     (out_max_offset_ns)
  );

endmodule
